@@ rtl/skht_pkg.sv @@
// Package for the string-key hash table: widths, status codes, controller commands.
// No dependencies.
`timescale 1ns / 1ps
package skht_pkg;
    localparam int TABLE_SLOTS = 256;
    localparam int KEY_BYTES   = 32;
    localparam int VALUE_BITS  = 32;
    localparam logic [31:0] HASH_START = 32'd5381;
    localparam int HASH_SHIFT  = 5;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_FIND   = 2'd1;
    localparam logic [1:0] KIND_ERASE  = 2'd2;
    localparam logic [1:0] KIND_NOP    = 2'd3;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_UPDATED   = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_FOUND     = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_ERASED    = 3'd5;
    localparam logic [2:0] ST_TOO_LONG  = 3'd6;
    localparam logic [2:0] ST_BAD_VALUE = 3'd7;

    // controller -> datapath
    typedef struct packed {
        logic take_byte;  // buffer and hash the input byte
        logic clr_key;    // return key state to reset
        logic ld_slot;    // probe slot, home slot <- hash modulo slot count
        logic rd_slot;    // read slot value / length at probe slot
        logic clr_cmp;    // compare index <- 0
        logic rd_cmp;     // read stored key byte and buffered byte at compare index
        logic nxt_cmp;    // compare index + 1
        logic nxt_slot;   // advance probe slot
        logic wr_new;     // write length, value; count up
        logic wr_key;     // write key byte at compare index into probe slot
        logic wr_upd;     // overwrite value
        logic wr_del;     // clear slot, count down
        logic clr_next;   // clearing pass: clear value at sweep index
        logic set_res;    // capture result
        logic [2:0] res_status;
        logic res_value;  // report stored value
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic overflow;
        logic bad_value;
        logic full_count;
        logic slot_empty;
        logic len_match;
        logic len_zero;
        logic byte_match;
        logic cmp_done;   // compare index reached key length
        logic circle_done;
        logic clear_done;
    } t_sts;
endpackage

@@ rtl/string_key_hash_table_unit.sv @@
// Top level of the string-key hash table: joins controller and datapath.
// Depends on skht_pkg, skht_ctrl, skht_dp.
//
// Use: key bytes arrive on the slave stream, one per request; tdata holds
// key_byte then value, tuser the kind, tlast marks the final key byte.
// A key with kind 3 is dropped with no result. On every other final byte
// the block hashes (DJB2, modulo slot count), probes linearly from the home
// slot and returns one result on the master stream: tdata holds
// status, value_out, entry_count_out.
// Flow: a non-final byte is taken in the idle state. After a final byte
// tready stays low through decide, each slot read and key byte compare,
// the key write of a fresh insert, and done. Too long, zero value and
// full count go from decide straight to done; kind 3 returns to idle.
// The result is valid from the done cycle on.
// After reset the value store is swept, one slot a cycle, with tready low.
// A result waits in an output register; while it is not taken the next
// final byte holds before its probe.
`timescale 1ns / 1ps
module string_key_hash_table_unit #(
    parameter int TABLE_SLOTS = skht_pkg::TABLE_SLOTS,
    parameter int KEY_BYTES   = skht_pkg::KEY_BYTES,
    parameter int VALUE_BITS  = skht_pkg::VALUE_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // key_byte[7:0], value[39:8]
    input  logic [1:0]  s_axis_tuser,   // kind
    input  logic        s_axis_tlast,   // key_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // status[2:0], value_out[34:3], entry_count_out[43:35]
);
    skht_pkg::t_cmd w_cmd;
    skht_pkg::t_sts w_sts;
    logic [2:0]  w_status;
    logic [31:0] w_value;
    logic [8:0]  w_count;

    skht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_kind     (s_axis_tuser),
        .i_last     (s_axis_tlast),
        .i_out_busy (m_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    skht_dp #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .KEY_BYTES   (KEY_BYTES),
        .VALUE_BITS  (VALUE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_key_byte    (s_axis_tdata[7:0]),
        .i_value       (s_axis_tdata[39:8]),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_status      (w_status),
        .o_value_out   (w_value),
        .o_entry_count (w_count)
    );

    assign m_axis_tdata = {4'd0, w_count, w_value, w_status};
endmodule

@@ rtl/skht_ctrl.sv @@
// Controller state machine for the string-key hash table.
// Depends on skht_pkg.
`timescale 1ns / 1ps
module skht_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [1:0]          i_kind,
    input  logic                i_last,
    input  logic                i_out_busy,
    output logic                o_in_ready,
    output skht_pkg::t_cmd      o_cmd,
    input  skht_pkg::t_sts      i_sts
);
    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DECIDE = 4'd2;
    localparam logic [3:0] S_RDSLOT = 4'd3;
    localparam logic [3:0] S_SLOT   = 4'd4;
    localparam logic [3:0] S_RDCMP  = 4'd5;
    localparam logic [3:0] S_CMP    = 4'd6;
    localparam logic [3:0] S_WRKEY  = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    logic [3:0] r_state, n_state;
    logic [1:0] r_kind, n_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_kind  <= skht_pkg::KIND_INSERT;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_next = 1'b1;
                if (i_sts.clear_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take_byte = 1'b1;
                    if (i_last) begin
                        n_kind = i_kind;
                        n_state = S_DECIDE;
                    end
                end
            end
            S_DECIDE: begin
                if (r_kind == skht_pkg::KIND_NOP) begin
                    o_cmd.clr_key = 1'b1;
                    n_state = S_IDLE;
                end else if (i_out_busy) begin
                    n_state = S_DECIDE;
                end else if (i_sts.overflow) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res_status = skht_pkg::ST_TOO_LONG;
                    n_state = S_DONE;
                end else if (r_kind == skht_pkg::KIND_INSERT && i_sts.bad_value) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res_status = skht_pkg::ST_BAD_VALUE;
                    n_state = S_DONE;
                end else if (r_kind == skht_pkg::KIND_INSERT && i_sts.full_count) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res_status = skht_pkg::ST_FULL;
                    n_state = S_DONE;
                end else begin
                    o_cmd.ld_slot = 1'b1;
                    n_state = S_RDSLOT;
                end
            end
            S_RDSLOT: begin
                o_cmd.rd_slot = 1'b1;
                o_cmd.clr_cmp = 1'b1;
                n_state = S_SLOT;
            end
            S_SLOT: begin
                if (i_sts.slot_empty) begin
                    if (r_kind == skht_pkg::KIND_INSERT) begin
                        o_cmd.wr_new = 1'b1;
                        n_state = S_WRKEY;
                    end else begin
                        o_cmd.set_res = 1'b1;
                        o_cmd.res_status = skht_pkg::ST_NOT_FOUND;
                        n_state = S_DONE;
                    end
                end else if (i_sts.len_match) begin
                    n_state = i_sts.len_zero ? S_CMP : S_RDCMP;
                end else begin
                    o_cmd.nxt_slot = 1'b1;
                    n_state = S_RDSLOT;
                    if (i_sts.circle_done) begin
                        o_cmd.nxt_slot = 1'b0;
                        o_cmd.set_res = 1'b1;
                        o_cmd.res_status = (r_kind == skht_pkg::KIND_INSERT)
                            ? skht_pkg::ST_FULL : skht_pkg::ST_NOT_FOUND;
                        n_state = S_DONE;
                    end
                end
            end
            S_RDCMP: begin
                // fetch stored and buffered byte at the compare index
                o_cmd.rd_cmp = 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (i_sts.cmp_done) begin
                    o_cmd.set_res = 1'b1;
                    n_state = S_DONE;
                    case (r_kind)
                        skht_pkg::KIND_INSERT: begin
                            o_cmd.wr_upd = 1'b1;
                            o_cmd.res_status = skht_pkg::ST_UPDATED;
                        end
                        skht_pkg::KIND_FIND: begin
                            o_cmd.res_value = 1'b1;
                            o_cmd.res_status = skht_pkg::ST_FOUND;
                        end
                        default: begin
                            o_cmd.wr_del = 1'b1;
                            o_cmd.res_status = skht_pkg::ST_ERASED;
                        end
                    endcase
                end else if (i_sts.byte_match) begin
                    o_cmd.nxt_cmp = 1'b1;
                    n_state = S_RDCMP;
                end else if (i_sts.circle_done) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res_status = (r_kind == skht_pkg::KIND_INSERT)
                        ? skht_pkg::ST_FULL : skht_pkg::ST_NOT_FOUND;
                    n_state = S_DONE;
                end else begin
                    o_cmd.nxt_slot = 1'b1;
                    n_state = S_RDSLOT;
                end
            end
            S_WRKEY: begin
                if (i_sts.cmp_done) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res_status = skht_pkg::ST_INSERTED;
                    n_state = S_DONE;
                end else begin
                    o_cmd.wr_key = 1'b1;
                    o_cmd.nxt_cmp = 1'b1;
                end
            end
            S_DONE: begin
                o_cmd.clr_key = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

@@ rtl/skht_dp.sv @@
// Datapath: key buffer, DJB2 hash, slot stores, probe and compare counters, result register.
// Depends on skht_pkg.
`timescale 1ns / 1ps
module skht_dp #(
    parameter int TABLE_SLOTS = skht_pkg::TABLE_SLOTS,
    parameter int KEY_BYTES   = skht_pkg::KEY_BYTES,
    parameter int VALUE_BITS  = skht_pkg::VALUE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [7:0]            i_key_byte,
    input  logic [31:0]           i_value,
    input  skht_pkg::t_cmd        i_cmd,
    output skht_pkg::t_sts        o_sts,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [2:0]            o_status,
    output logic [31:0]           o_value_out,
    output logic [8:0]            o_entry_count
);
    localparam int SW = (TABLE_SLOTS > 2) ? $clog2(TABLE_SLOTS) : 1;
    localparam int KW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
    localparam int LW = $clog2(KEY_BYTES + 1);
    localparam int CW = $clog2(TABLE_SLOTS + 1);
    localparam int VW = (VALUE_BITS < 32) ? VALUE_BITS : 32;

    logic [7:0]            r_kbuf [KEY_BYTES];
    logic [LW-1:0]         r_klen;
    logic [31:0]           r_hash;
    logic                  r_ovf;
    logic [VW-1:0]         r_val_in;

    logic [7:0]            m_key [TABLE_SLOTS*KEY_BYTES];
    logic [LW-1:0]         m_len [TABLE_SLOTS];
    logic [VW-1:0]         m_val [TABLE_SLOTS];

    logic [CW-1:0]         r_count;
    logic [SW-1:0]         r_slot, r_home, r_sweep;
    logic [LW-1:0]         r_cmp;
    logic [LW-1:0]         r_rd_len;
    logic [VW-1:0]         r_rd_val;
    logic [7:0]            r_rd_key, r_rd_buf;
    logic                  r_out_valid;
    logic [2:0]            r_status;
    logic [31:0]           r_value_out;
    logic                  r_sweep_done;
    logic [$clog2(TABLE_SLOTS*KEY_BYTES)-1:0] n_key_addr;

    assign n_key_addr = ($clog2(TABLE_SLOTS*KEY_BYTES))'(r_slot) * ($clog2(TABLE_SLOTS*KEY_BYTES))'(KEY_BYTES)
                      + ($clog2(TABLE_SLOTS*KEY_BYTES))'(r_cmp[KW-1:0]);

    // key intake and DJB2 hash
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_key) begin
            r_klen <= '0;
            r_hash <= skht_pkg::HASH_START;
            r_ovf  <= 1'b0;
        end else if (i_cmd.take_byte) begin
            if (r_klen < LW'(KEY_BYTES)) r_klen <= r_klen + 1'b1;
            else r_ovf <= 1'b1;
            r_hash <= (r_hash << skht_pkg::HASH_SHIFT) + r_hash + {24'd0, i_key_byte};
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_byte) begin
            if (r_klen < LW'(KEY_BYTES)) r_kbuf[r_klen[KW-1:0]] <= i_key_byte;
            r_val_in <= i_value[VW-1:0];
        end
    end

    // slot stores
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_next) m_val[r_sweep] <= '0;
        else if (i_cmd.wr_new || i_cmd.wr_upd) m_val[r_slot] <= r_val_in;
        else if (i_cmd.wr_del) m_val[r_slot] <= '0;
        if (i_cmd.rd_slot) r_rd_val <= m_val[r_slot];
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_new) m_len[r_slot] <= r_klen;
        else if (i_cmd.wr_del) m_len[r_slot] <= '0;
        if (i_cmd.rd_slot) r_rd_len <= m_len[r_slot];
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_key) m_key[n_key_addr] <= r_kbuf[r_cmp[KW-1:0]];
        if (i_cmd.rd_cmp) r_rd_key <= m_key[n_key_addr];
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_cmp) r_rd_buf <= r_kbuf[r_cmp[KW-1:0]];
    end

    // counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sweep <= '0;
            r_sweep_done <= 1'b0;
        end else begin
            if (i_cmd.clr_next) begin
                r_sweep <= r_sweep + 1'b1;
                if (r_sweep == SW'(TABLE_SLOTS - 1)) r_sweep_done <= 1'b1;
            end
            if (i_cmd.wr_new) r_count <= r_count + 1'b1;
            else if (i_cmd.wr_del && r_count != '0) r_count <= r_count - 1'b1;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_slot) begin
            r_slot <= SW'(r_hash % TABLE_SLOTS);
            r_home <= SW'(r_hash % TABLE_SLOTS);
        end else if (i_cmd.nxt_slot) begin
            r_slot <= (r_slot == SW'(TABLE_SLOTS - 1)) ? '0 : r_slot + 1'b1;
        end
        if (i_cmd.clr_cmp) r_cmp <= '0;
        else if (i_cmd.nxt_cmp) r_cmp <= r_cmp + 1'b1;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.set_res) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_res) begin
            r_status <= i_cmd.res_status;
            r_value_out <= i_cmd.res_value ? 32'(r_rd_val) : 32'd0;
        end
    end

    logic [SW-1:0] n_next_slot;
    assign n_next_slot = (r_slot == SW'(TABLE_SLOTS - 1)) ? '0 : r_slot + 1'b1;

    always_comb begin
        o_sts.overflow    = r_ovf;
        o_sts.bad_value   = (r_val_in == '0);
        o_sts.full_count  = (r_count >= CW'(TABLE_SLOTS));
        o_sts.slot_empty  = (r_rd_val == '0);
        o_sts.len_match   = (r_rd_len == r_klen);
        o_sts.len_zero    = (r_klen == '0);
        o_sts.byte_match  = (r_rd_key == r_rd_buf);
        o_sts.cmp_done    = (r_cmp == r_klen);
        o_sts.circle_done = (n_next_slot == r_home);
        o_sts.clear_done  = r_sweep_done;
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_value_out   = r_value_out;
    assign o_entry_count = 9'(r_count);
endmodule

@@ sim/tb.sv @@
// Testbench for string_key_hash_table_unit: streams insert/find/erase/nop keys,
// predicts each result with a behavioural hash table and compares. Depends on skht_pkg.
`timescale 1ns / 1ps
module tb;
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  key_byte;
        logic        key_last;
        logic [31:0] value;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] value_out;
        logic [8:0]  entry_count;
    } t_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;

    string_key_hash_table_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // table predictor state
    logic [7:0]  tbl_key [skht_pkg::TABLE_SLOTS][skht_pkg::KEY_BYTES];
    int          tbl_len [skht_pkg::TABLE_SLOTS];
    logic [31:0] tbl_val [skht_pkg::TABLE_SLOTS];
    int          n_entries;
    logic [7:0]  cur_key [skht_pkg::KEY_BYTES];
    int          cur_len;
    logic [31:0] cur_hash;
    bit          cur_over;

    t_req pending_reqs[$];
    t_res expected_results[$];
    int   n_fail = 0;
    int   n_checked = 0;
    int   n_accepted = 0;
    bit   quiet_phase = 0;
    bit   hold_off = 0;

    // key pool for collisions and repeats
    typedef struct {
        int len;
        logic [7:0] b [skht_pkg::KEY_BYTES+4];
    } t_key;
    t_key key_pool[$];

    function automatic bit key_matches(int slot);
        if (tbl_len[slot] != cur_len) return 0;
        for (int i = 0; i < cur_len; i++)
            if (tbl_key[slot][i] != cur_key[i]) return 0;
        return 1;
    endfunction

    task automatic predict_table(input t_req r);
        int home, idx, where;
        bit hit, empty_seen;
        t_res res;
        hit = 0; empty_seen = 0; where = 0;
        res = '0;
        if (cur_len < skht_pkg::KEY_BYTES) begin
            cur_key[cur_len] = r.key_byte;
            cur_len++;
        end else cur_over = 1;
        cur_hash = (cur_hash << skht_pkg::HASH_SHIFT) + cur_hash + r.key_byte;
        if (!r.key_last) return;
        if (r.kind != skht_pkg::KIND_NOP) begin
            if (cur_over) res.status = skht_pkg::ST_TOO_LONG;
            else if (r.kind == skht_pkg::KIND_INSERT && r.value == 0)
                res.status = skht_pkg::ST_BAD_VALUE;
            else if (r.kind == skht_pkg::KIND_INSERT && n_entries >= skht_pkg::TABLE_SLOTS)
                res.status = skht_pkg::ST_FULL;
            else begin
                home = cur_hash % skht_pkg::TABLE_SLOTS;
                idx = home;
                for (int n = 0; n < skht_pkg::TABLE_SLOTS; n++) begin
                    if (tbl_val[idx] == 0) begin
                        empty_seen = 1; where = idx; break;
                    end
                    if (key_matches(idx)) begin
                        hit = 1; where = idx; break;
                    end
                    idx = (idx + 1) % skht_pkg::TABLE_SLOTS;
                end
                case (r.kind)
                    skht_pkg::KIND_INSERT: begin
                        if (hit) begin
                            tbl_val[where] = r.value;
                            res.status = skht_pkg::ST_UPDATED;
                        end else if (empty_seen) begin
                            for (int i = 0; i < cur_len; i++) tbl_key[where][i] = cur_key[i];
                            tbl_len[where] = cur_len;
                            tbl_val[where] = r.value;
                            n_entries++;
                            res.status = skht_pkg::ST_INSERTED;
                        end else res.status = skht_pkg::ST_FULL;
                    end
                    skht_pkg::KIND_FIND: begin
                        if (hit) begin
                            res.status = skht_pkg::ST_FOUND;
                            res.value_out = tbl_val[where];
                        end else res.status = skht_pkg::ST_NOT_FOUND;
                    end
                    default: begin
                        if (hit) begin
                            tbl_len[where] = 0;
                            tbl_val[where] = 0;
                            if (n_entries > 0) n_entries--;
                            res.status = skht_pkg::ST_ERASED;
                        end else res.status = skht_pkg::ST_NOT_FOUND;
                    end
                endcase
            end
            res.entry_count = n_entries[8:0];
            expected_results.push_back(res);
        end
        cur_len = 0; cur_hash = skht_pkg::HASH_START; cur_over = 0;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0h expected %0h (result %0d)", what, got, want, n_checked);
        n_fail++;
    endtask

    // queue one key as a run of requests
    task automatic queue_key(input logic [1:0] kind, input t_key k, input logic [31:0] v);
        t_req r;
        for (int i = 0; i < k.len; i++) begin
            r.kind = (i == k.len - 1) ? kind : 2'($urandom_range(0, 3));
            r.key_byte = k.b[i];
            r.key_last = (i == k.len - 1);
            r.value = (i == k.len - 1) ? v : $urandom;
            pending_reqs.push_back(r);
        end
    endtask

    function automatic t_key random_key(int maxlen);
        t_key k;
        k.len = $urandom_range(1, maxlen);
        for (int i = 0; i < skht_pkg::KEY_BYTES + 4; i++)
            k.b[i] = (i < k.len) ? 8'($urandom) : 8'h00;
        return k;
    endfunction

    // sender
    int src_gap = 0;
    always @(posedge i_clk) begin
        t_req r;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r = {s_axis_tuser, s_axis_tdata[7:0], s_axis_tlast, s_axis_tdata[39:8]};
                predict_table(r);
                n_accepted++;
            end
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (!quiet_phase && $urandom_range(0, 19) == 0) begin
                    src_gap = $urandom_range(0, 13);
                    s_axis_tvalid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    r = pending_reqs.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {r.value, r.key_byte};
                    s_axis_tuser <= r.kind;
                    s_axis_tlast <= r.key_last;
                end else s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver and checker
    int snk_gap = 0;
    always @(posedge i_clk) begin
        t_res got, want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[2:0], m_axis_tdata[34:3], m_axis_tdata[43:35]};
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", 32'(got.status), 32'd0);
                end else begin
                    want = expected_results.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", 32'(got.status), 32'(want.status));
                    if (got.value_out != want.value_out)
                        report_mismatch("value_out", got.value_out, want.value_out);
                    if (got.entry_count != want.entry_count)
                        report_mismatch("entry_count", 32'(got.entry_count),
                                        32'(want.entry_count));
                end
                n_checked++;
            end
            if (hold_off) m_axis_tready <= 1'b0;
            else if (snk_gap > 0) begin
                snk_gap--;
                m_axis_tready <= 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 14) == 0) begin
                snk_gap = $urandom_range(0, 13);
                m_axis_tready <= 1'b0;
            end else m_axis_tready <= 1'b1;
        end
    end

    // long receiver hold-off once the block takes requests
    initial begin
        @(posedge i_clk);
        while (!i_rst_n || !s_axis_tready) @(posedge i_clk);
        hold_off = 1;
        repeat (400) @(posedge i_clk);
        hold_off = 0;
    end

    initial begin
        #40000000;
        $display("Timeout");
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        t_key k, big;
        int sel, op;
        for (int s = 0; s < skht_pkg::TABLE_SLOTS; s++) begin
            tbl_val[s] = 0; tbl_len[s] = 0;
        end
        n_entries = 0; cur_len = 0; cur_hash = skht_pkg::HASH_START; cur_over = 0;

        // directed: extremes, every operation, special cases
        k.len = 1; k.b[0] = 8'h00;
        queue_key(skht_pkg::KIND_FIND, k, 32'd0);
        queue_key(skht_pkg::KIND_INSERT, k, 32'hFFFF_FFFF);
        queue_key(skht_pkg::KIND_INSERT, k, 32'd1);
        queue_key(skht_pkg::KIND_FIND, k, 32'd0);
        queue_key(skht_pkg::KIND_INSERT, k, 32'd0);
        k.b[0] = 8'hFF;
        queue_key(skht_pkg::KIND_INSERT, k, 32'hA5A5_5A5A);
        queue_key(skht_pkg::KIND_NOP, k, 32'd7);
        queue_key(skht_pkg::KIND_ERASE, k, 32'd0);
        queue_key(skht_pkg::KIND_ERASE, k, 32'd0);
        big = random_key(1); big.len = skht_pkg::KEY_BYTES;
        for (int i = 0; i < skht_pkg::KEY_BYTES; i++) big.b[i] = 8'($urandom);
        queue_key(skht_pkg::KIND_INSERT, big, 32'h5A5A_A5A5);
        queue_key(skht_pkg::KIND_FIND, big, 32'd0);
        big.len = skht_pkg::KEY_BYTES + 2;
        queue_key(skht_pkg::KIND_INSERT, big, 32'd3);

        // offered while the receiver holds off
        for (int i = 0; i < 30; i++)
            queue_key(skht_pkg::KIND_INSERT, random_key(3), $urandom | 1);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // random: mostly short keys from a pool so ops hit existing entries
        for (int i = 0; i < 60; i++) key_pool.push_back(random_key(4));
        while (n_accepted + pending_reqs.size() < 1280) begin
            if (pending_reqs.size() > 40) begin
                @(posedge i_clk);
                continue;
            end
            sel = $urandom_range(0, 9);
            if (sel < 7) k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            else if (sel < 9) k = random_key(6);
            else k = random_key(skht_pkg::KEY_BYTES + 3);
            op = $urandom_range(0, 19);
            if (op < 9) queue_key(skht_pkg::KIND_INSERT, k, (op == 0) ? 32'd0 : $urandom);
            else if (op < 14) queue_key(skht_pkg::KIND_FIND, k, $urandom);
            else if (op < 19) queue_key(skht_pkg::KIND_ERASE, k, $urandom);
            else queue_key(skht_pkg::KIND_NOP, k, $urandom);
        end
        // fill towards a full table, then quiet tail
        while (pending_reqs.size() > 0) @(posedge i_clk);
        for (int i = 0; i < 80; i++)
            queue_key(skht_pkg::KIND_INSERT, random_key(2), $urandom | 1);
        while (pending_reqs.size() > 0 || s_axis_tvalid) @(posedge i_clk);
        quiet_phase = 1;
        for (int i = 0; i < 20; i++) begin
            k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            queue_key(i[0] ? skht_pkg::KIND_FIND : skht_pkg::KIND_ERASE, k, 32'd0);
        end
        while (pending_reqs.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (2000) @(posedge i_clk);

        $display("Ran %0d key-byte requests, checked %0d results, %0d entries at end",
                 n_accepted, n_checked, n_entries);
        if (n_fail == 0 && expected_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

@@ files.f @@
rtl/skht_pkg.sv
rtl/skht_ctrl.sv
rtl/skht_dp.sv
rtl/string_key_hash_table_unit.sv
sim/tb.sv
